// ===== rtl/core/bse_pkg.sv =====
// Package for the battery SOC estimator: controller states, command and
// status structs, open-circuit voltage table and arithmetic constants.
// No dependencies.
package bse_pkg;

    localparam int OCV_POINTS = 11;
    localparam int MV_W       = 13;
    localparam int SEG_W      = 4;
    localparam int SOC_W      = 7;
    localparam int NUM_W      = 39;
    localparam int DEN_W      = 32;
    localparam int REM_W      = 32;
    localparam int QMAG_W     = 17;
    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CAP_W      = 10;
    localparam int LIMIT_W    = 17;
    localparam int RUN_W      = 16;
    localparam int CUR_W      = 21;
    localparam int CHG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [SOC_W-1:0] SOC_MAX   = 7'd100;
    localparam logic [SOC_W-1:0] SOC_STEP  = 7'd10;
    localparam logic [21:0]      MAS_PER_AH = 22'd3600000;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 10'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1000;
    localparam logic [RUN_W-1:0]   RUN_RESET   = 16'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN      = 2'd2;

    localparam logic [SEG_W-1:0] SEG_BELOW = 4'd0;
    localparam logic [SEG_W-1:0] SEG_ABOVE = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_div;
        logic div_step;
        logic finish;
    } t_bse_cmd;

    typedef struct packed {
        logic div_last;
    } t_bse_sts;

    function automatic logic [MV_W-1:0] ocv_point(input logic [SEG_W-1:0] idx);
        logic [MV_W-1:0] mv;
        unique case (idx)
            4'd0:    mv = 13'd3300;
            4'd1:    mv = 13'd3400;
            4'd2:    mv = 13'd3450;
            4'd3:    mv = 13'd3500;
            4'd4:    mv = 13'd3560;
            4'd5:    mv = 13'd3600;
            4'd6:    mv = 13'd3700;
            4'd7:    mv = 13'd3800;
            4'd8:    mv = 13'd4000;
            4'd9:    mv = 13'd4100;
            default: mv = 13'd4200;
        endcase
        return mv;
    endfunction

    function automatic logic [SEG_W-1:0] ocv_segment(input logic [MV_W-1:0] mv);
        logic [SEG_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < OCV_POINTS; i++) begin
            cnt = cnt + SEG_W'(mv >= ocv_point(SEG_W'(i)));
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/battery_soc_estimator.sv =====
// Battery SOC estimator: an accepted transaction passes through operand
// setup, 39 steps of the shared restoring divider and a result write; a new
// transaction is accepted only after that result is written. The divider
// produces one quotient bit per cycle.
// Synchronous active-low reset restores register defaults, zero SOC and count.
// Top level; depends on bse_pkg, bse_ctrl and bse_datapath.
module battery_soc_estimator #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [bse_pkg::CUR_W-1:0]    i_pack_current_ma,
    input  logic [bse_pkg::MV_W-1:0]            i_lowest_cell_mv,
    input  logic signed [bse_pkg::CHG_W-1:0]    i_charge_delta_mas,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [bse_pkg::SOC_W-1:0]           o_soc_percent,
    output logic                                o_from_voltage
);
    import bse_pkg::*;

    t_bse_cmd cmd;
    t_bse_sts sts;

    bse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bse_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_pack_current_ma  (i_pack_current_ma),
        .i_lowest_cell_mv   (i_lowest_cell_mv),
        .i_charge_delta_mas (i_charge_delta_mas),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_soc_percent      (o_soc_percent),
        .o_from_voltage     (o_from_voltage)
    );

endmodule

// ===== rtl/core/bse_ctrl.sv =====
// Controller state machine for the battery SOC estimator.
// Sequences capture, operand setup, divider steps and result write.
// Depends on bse_pkg.
module bse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  bse_pkg::t_bse_sts i_sts,
    output bse_pkg::t_bse_cmd o_cmd
);
    import bse_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV:  if (i_sts.div_last) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_ready        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_PREP: o_cmd.load_div = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_DONE: o_cmd.finish   = out_free;
            default: o_ready       = 1'b0;
        endcase
    end

    assign n_out_valid = o_cmd.finish || (r_out_valid && !i_ready);
    assign o_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_ready))
        else $error("result written over a pending transaction");

    a_capture_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_PREP))
        else $error("capture not followed by operand setup");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_sts.div_last |=> (r_state == S_DONE))
        else $error("divider end missed");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input taken while busy");

endmodule

// ===== rtl/core/bse_datapath.sv =====
// Datapath for the battery SOC estimator: configuration registers, idle
// counter, operand multipliers, shared restoring divider and result logic.
// Depends on bse_pkg.
module bse_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [bse_pkg::CUR_W-1:0]    i_pack_current_ma,
    input  logic [bse_pkg::MV_W-1:0]            i_lowest_cell_mv,
    input  logic signed [bse_pkg::CHG_W-1:0]    i_charge_delta_mas,
    input  bse_pkg::t_bse_cmd                   i_cmd,
    output bse_pkg::t_bse_sts                   o_sts,
    output logic [bse_pkg::SOC_W-1:0]           o_soc_percent,
    output logic                                o_from_voltage
);
    import bse_pkg::*;

    localparam int CMP_W = (COUNT_BITS > RUN_W) ? COUNT_BITS : RUN_W;
    localparam int SUM_W = QMAG_W + 2;

    logic [CAP_W-1:0]      r_cap;
    logic [LIMIT_W-1:0]    r_limit;
    logic [RUN_W-1:0]      r_run;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [SOC_W-1:0]      r_soc, n_soc;
    logic                  r_from_v;

    logic [CHG_W-1:0]      r_charge_mag;
    logic                  r_neg;
    logic [MV_W-1:0]       r_mv;
    logic                  r_use_v;
    logic [SEG_W-1:0]      r_seg;

    logic [NUM_W-1:0]      r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [DEN_W-1:0]      r_den;
    logic [STEP_W-1:0]     r_step;

    logic [CUR_W-1:0]      cur_mag;
    logic [CHG_W-1:0]      chg_mag;
    logic                  idle;
    logic                  use_v;
    logic [SEG_W-1:0]      seg;
    logic [MV_W-1:0]       pt_lo;
    logic [MV_W-1:0]       span;
    logic [MV_W-1:0]       off;
    logic [CAP_W-1:0]      cap_eff;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;
    logic [REM_W:0]        r2;
    logic                  ge;
    logic [QMAG_W-1:0]     qmag;
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] sum;
    logic [SOC_W-1:0]      soc_v;
    logic [SOC_W-1:0]      soc_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_limit <= LIMIT_RESET;
            r_run   <= RUN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: r_cap   <= i_cfg_data[CAP_W-1:0];
                CFG_LIMIT:    r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_RUN:      r_run   <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cur_mag = i_pack_current_ma[CUR_W-1] ? CUR_W'(-i_pack_current_ma)
                                                : CUR_W'(i_pack_current_ma);
    assign chg_mag = i_charge_delta_mas[CHG_W-1] ? CHG_W'(-i_charge_delta_mas)
                                                 : CHG_W'(i_charge_delta_mas);
    assign idle    = cur_mag < CUR_W'(r_limit);

    always_comb begin
        n_count = r_count;
        if (!idle) begin
            n_count = '0;
        end else if (r_count != {COUNT_BITS{1'b1}}) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    assign use_v = CMP_W'(n_count) > CMP_W'(r_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.capture) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_charge_mag <= chg_mag;
            r_neg        <= i_charge_delta_mas[CHG_W-1];
            r_mv         <= i_lowest_cell_mv;
            r_use_v      <= use_v;
        end
    end

    assign seg     = ocv_segment(r_mv);
    assign pt_lo   = ocv_point(seg - SEG_W'(1));
    assign span    = ocv_point(seg) - pt_lo;
    assign off     = r_mv - pt_lo;
    assign cap_eff = (r_cap == '0) ? CAP_W'(1) : r_cap;

    always_comb begin
        if (r_use_v) begin
            num = NUM_W'(off) * NUM_W'(SOC_STEP);
            den = DEN_W'(span);
        end else begin
            num = NUM_W'(r_charge_mag) * NUM_W'(SOC_MAX);
            den = DEN_W'(MAS_PER_AH) * DEN_W'(cap_eff);
        end
    end

    assign r2 = {r_rem, r_quo[NUM_W-1]};
    assign ge = r2 >= {1'b0, r_den};
    assign o_sts.div_last = (r_step == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo  <= num;
            r_den  <= den;
            r_rem  <= '0;
            r_seg  <= seg;
            r_step <= STEP_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[NUM_W-2:0], ge};
            r_rem  <= ge ? REM_W'(r2 - {1'b0, r_den}) : r2[REM_W-1:0];
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign qmag = r_quo[QMAG_W-1:0];

    always_comb begin
        if (r_neg) begin
            q = -($signed(SUM_W'(qmag)) + $signed(SUM_W'(r_rem != '0)));
        end else begin
            q = $signed(SUM_W'(qmag));
        end
        sum = $signed(SUM_W'(r_soc)) + q;
        if (sum < 0) begin
            soc_c = '0;
        end else if (sum > $signed(SUM_W'(SOC_MAX))) begin
            soc_c = SOC_MAX;
        end else begin
            soc_c = sum[SOC_W-1:0];
        end
        if (r_seg == SEG_BELOW) begin
            soc_v = '0;
        end else if (r_seg >= SEG_ABOVE) begin
            soc_v = SOC_MAX;
        end else begin
            soc_v = SOC_W'(SOC_STEP * SOC_W'(r_seg - SEG_W'(1))) + SOC_W'(r_quo[3:0]);
        end
        n_soc = r_use_v ? soc_v : soc_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soc    <= '0;
            r_from_v <= 1'b0;
        end else if (i_cmd.finish) begin
            r_soc    <= n_soc;
            r_from_v <= r_use_v;
        end
    end

    assign o_soc_percent  = r_soc;
    assign o_from_voltage = r_from_v;

endmodule

// ===== sim/tb_battery_soc_estimator.sv =====
// Self-checking testbench for battery_soc_estimator: a scoreboard class predicts
// each SOC update, tasks drive samples and register writes, a sink drives output stalls.
// Depends on bse_pkg and the battery_soc_estimator RTL.
`timescale 1ns / 1ps

localparam int COUNT_BITS = 16;
localparam int OCV_MV [11] = '{3300, 3400, 3450, 3500, 3560, 3600, 3700, 3800,
                               4000, 4100, 4200};
localparam logic [bse_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

typedef struct {
    logic signed [bse_pkg::CUR_W-1:0] cur;
    logic [bse_pkg::MV_W-1:0]         mv;
    logic signed [bse_pkg::CHG_W-1:0] chg;
} t_soc_sample;

typedef struct {
    logic [bse_pkg::SOC_W-1:0] soc;
    logic                      from_v;
} t_soc_result;

class soc_tracker;
    logic [bse_pkg::CAP_W-1:0]   capacity;
    logic [bse_pkg::LIMIT_W-1:0] idle_limit;
    logic [bse_pkg::RUN_W-1:0]   run_len;
    logic [bse_pkg::SOC_W-1:0]   soc;
    logic [COUNT_BITS-1:0]       idle_cnt;
    t_soc_result                 pending_socs[$];
    int failures;
    int checked;
    int voltage_hits;
    int settings;

    function new();
        capacity     = bse_pkg::CAP_RESET;
        idle_limit   = bse_pkg::LIMIT_RESET;
        run_len      = bse_pkg::RUN_RESET;
        soc          = '0;
        idle_cnt     = '0;
        failures     = 0;
        checked      = 0;
        voltage_hits = 0;
        settings     = 1;
    endfunction

    function void write_reg(logic [bse_pkg::CFG_IDX_W-1:0] idx,
                            logic [bse_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bse_pkg::CFG_CAPACITY: capacity = data[bse_pkg::CAP_W-1:0];
            bse_pkg::CFG_LIMIT:    idle_limit = data[bse_pkg::LIMIT_W-1:0];
            bse_pkg::CFG_RUN:      run_len = data[bse_pkg::RUN_W-1:0];
            default: ;
        endcase
        settings++;
    endfunction

    function int soc_from_ocv(int mv);
        if (mv < OCV_MV[0]) return 0;
        for (int i = 1; i < 11; i++) begin
            if (mv < OCV_MV[i])
                return 10 * (i - 1) + (10 * (mv - OCV_MV[i-1])) / (OCV_MV[i] - OCV_MV[i-1]);
        end
        return 100;
    endfunction

    function int soc_from_coulombs(logic signed [bse_pkg::CHG_W-1:0] chg);
        longint cap_eff;
        longint den;
        longint num;
        longint q;
        longint sum;
        cap_eff = (capacity == 0) ? 64'd1 : longint'(capacity);
        den = 64'd3600000 * cap_eff;
        num = 64'd100 * longint'(chg);
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        sum = longint'(soc) + q;
        if (sum < 0) sum = 0;
        if (sum > 100) sum = 100;
        return int'(sum);
    endfunction

    function void note_sample(t_soc_sample s);
        int          mag;
        t_soc_result r;
        mag = (s.cur < 0) ? -int'(s.cur) : int'(s.cur);
        if (mag < int'(idle_limit)) begin
            if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
        end else begin
            idle_cnt = '0;
        end
        r.from_v = (idle_cnt > COUNT_BITS'(run_len));
        if (r.from_v) soc = bse_pkg::SOC_W'(soc_from_ocv(int'(s.mv)));
        else soc = bse_pkg::SOC_W'(soc_from_coulombs(s.chg));
        r.soc = soc;
        pending_socs.push_back(r);
    endfunction

    function void note_failure(string what, int exp_soc, int exp_v, int got_soc, int got_v);
        failures++;
        if (failures <= 10)
            $display("MISMATCH %s: expected soc=%0d from_voltage=%0d, got soc=%0d from_voltage=%0d",
                     what, exp_soc, exp_v, got_soc, got_v);
    endfunction

    function void check_result(logic [bse_pkg::SOC_W-1:0] got_soc, logic got_v);
        t_soc_result r;
        if (pending_socs.size() == 0) begin
            note_failure("unexpected result", -1, -1, got_soc, got_v);
            return;
        end
        r = pending_socs.pop_front();
        checked++;
        if (r.from_v) voltage_hits++;
        if (got_soc !== r.soc || got_v !== r.from_v)
            note_failure($sformatf("result %0d", checked), r.soc, r.from_v, got_soc, got_v);
    endfunction

    function int pending();
        return pending_socs.size();
    endfunction

    function void flush_leftovers();
        while (pending_socs.size() > 0) begin
            t_soc_result r;
            r = pending_socs.pop_front();
            note_failure("missing result", r.soc, r.from_v, -1, -1);
        end
    endfunction
endclass

module tb_battery_soc_estimator;
    localparam int LATENCY     = 42;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [bse_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [bse_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                               i_valid = 1'b0;
    logic                               o_ready;
    logic signed [bse_pkg::CUR_W-1:0]   i_pack_current_ma = '0;
    logic [bse_pkg::MV_W-1:0]           i_lowest_cell_mv = '0;
    logic signed [bse_pkg::CHG_W-1:0]   i_charge_delta_mas = '0;
    logic                               o_valid;
    logic                               i_ready = 1'b0;
    logic [bse_pkg::SOC_W-1:0]          o_soc_percent;
    logic                               o_from_voltage;

    soc_tracker tracker = new();
    bit         steady_flow = 1'b0;
    int         hold_seq = 0;
    int         cycle_count = 0;
    int         samples_sent = 0;

    battery_soc_estimator #(.COUNT_BITS(COUNT_BITS)) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pack_current_ma  (i_pack_current_ma),
        .i_lowest_cell_mv   (i_lowest_cell_mv),
        .i_charge_delta_mas (i_charge_delta_mas),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_soc_percent      (o_soc_percent),
        .o_from_voltage     (o_from_voltage)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tracker.pending());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        int hold_left;
        int hold_seen;
        stall = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                tracker.check_result(o_soc_percent, o_from_voltage);
                stall = steady_flow ? 0 : $urandom_range(0, 4);
            end else if (stall > 0 && o_valid) begin
                stall--;
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_ready <= i_rst_n && stall == 0 && hold_left == 0;
        end
    end

    task automatic send_sample(input int cur, input int mv, input int chg);
        int          gap;
        int          waited;
        bit          align;
        t_soc_sample s;
        s.cur = bse_pkg::CUR_W'(cur);
        s.mv  = bse_pkg::MV_W'(mv);
        s.chg = chg;
        gap   = steady_flow ? 0 : $urandom_range(0, 4);
        align = $urandom_range(0, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            waited = 0;
            while (gap > 0) begin
                @(posedge i_clk);
                if (!align || o_ready || waited >= 64) gap--;
                waited++;
            end
        end
        i_valid            <= 1'b1;
        i_pack_current_ma  <= s.cur;
        i_lowest_cell_mv   <= s.mv;
        i_charge_delta_mas <= s.chg;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_sample(s);
        samples_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bse_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_directed_cases();
        send_sample(1048575, 0, 2147483647);
        send_sample(-1048576, 8191, int'(32'h8000_0000));
        send_sample(5000, 3700, 36000000);
        send_sample(-5000, 3700, -1);
        send_sample(5000, 0, -3600000);
        drain_results();
        write_reg(bse_pkg::CFG_RUN, 17'd0);
        send_sample(0, 0, 0);
        send_sample(999, 3299, 0);
        send_sample(-999, 3300, 0);
        send_sample(0, 3349, 0);
        send_sample(0, 3399, 0);
        send_sample(0, 3400, 0);
        send_sample(0, 4199, 0);
        send_sample(0, 4200, 0);
        send_sample(0, 8191, 0);
        send_sample(1000, 4000, 0);
        send_sample(-1000, 4000, 36000000);
        drain_results();
        write_reg(bse_pkg::CFG_LIMIT, 17'd0);
        write_reg(bse_pkg::CFG_CAPACITY, 17'd0);
        write_reg(CFG_UNUSED, 17'h1FFFF);
        send_sample(0, 4200, 36000);
        send_sample(0, 4200, -72001);
        drain_results();
        write_reg(bse_pkg::CFG_LIMIT, 17'd131071);
        write_reg(bse_pkg::CFG_CAPACITY, 17'd1023);
        write_reg(bse_pkg::CFG_RUN, 17'd65535);
        send_sample(131070, 3600, 0);
        send_sample(-131071, 3600, 2147483647);
        send_sample(0, 3600, -2147483647);
    endtask

    function automatic int rand_current(int limit, bit want_idle);
        int                               mag;
        logic signed [bse_pkg::CUR_W-1:0] raw;
        if (want_idle && limit > 0) begin
            mag = $urandom_range(0, limit - 1);
        end else if ($urandom_range(0, 2) == 0) begin
            mag = limit + $urandom_range(0, 2);
        end else begin
            raw = bse_pkg::CUR_W'($urandom);
            return int'(raw);
        end
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int rand_mv();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 7) return $urandom_range(3250, 4250);
        if (sel == 8) return $urandom_range(0, 8191);
        return OCV_MV[$urandom_range(0, 10)] - $urandom_range(0, 1);
    endfunction

    function automatic int rand_charge(int cap_eff);
        int     sel;
        longint span;
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
            span = 64'd36000 * cap_eff * $urandom_range(1, 30);
            return int'(longint'($urandom_range(0, 32'(2 * span))) - span);
        end
        if (sel <= 8) return $urandom;
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 2147483647;
            default: return int'(32'h8000_0000);
        endcase
    endfunction

    task automatic run_random_phase(input int n, input int cap, input int limit,
                                    input int run, input bit pause_midway);
        int  sent;
        int  burst;
        int  cap_eff;
        bit  idle;
        cap_eff = (cap == 0) ? 1 : cap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(0, ((run < 20) ? run : 20) + 6);
            for (int j = 0; j <= burst && sent < n; j++) begin
                idle = (j < burst) || ($urandom_range(0, 3) == 0);
                send_sample(rand_current(limit, idle), rand_mv(), rand_charge(cap_eff));
                sent++;
                if (pause_midway && sent == n / 2) drain_results();
            end
        end
    endtask

    initial begin : stimulus
        int cap;
        int limit;
        int run;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed_cases();
        for (int ph = 0; ph < 12; ph++) begin
            drain_results();
            case (ph % 5)
                0:       cap = 1;
                1:       cap = 1000;
                2:       cap = 0;
                3:       cap = 1023;
                default: cap = $urandom_range(1, 1000);
            endcase
            if (ph == 6) limit = 0;
            else if (ph % 4 == 1) limit = 131071;
            else limit = $urandom_range(1, 5000);
            if (ph == 0) run = 0;
            else if (ph == 4) run = 65535;
            else if (ph == 8) run = $urandom_range(100, 65535);
            else run = $urandom_range(0, 12);
            write_reg(bse_pkg::CFG_CAPACITY,
                      {7'($urandom), bse_pkg::CAP_W'(cap)});
            write_reg(bse_pkg::CFG_LIMIT, bse_pkg::CFG_DATA_W'(limit));
            write_reg(bse_pkg::CFG_RUN, {1'($urandom), bse_pkg::RUN_W'(run)});
            if (ph == 9) write_reg(CFG_UNUSED, 17'($urandom));
            steady_flow <= (ph % 4 == 3);
            if (ph == 2) hold_seq <= hold_seq + 1;
            run_random_phase(86, cap, limit, run, ph == 5);
        end
        drain_results();
        tracker.flush_leftovers();
        $display("Covered %0d samples over %0d register settings: %0d from the voltage table, %0d coulomb counted",
                 samples_sent, tracker.settings, tracker.voltage_hits,
                 tracker.checked - tracker.voltage_hits);
        $display("Included a long output stall, drain pauses and %0d failures in total",
                 tracker.failures);
        if (tracker.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
